[hdl/meadj_pkg.sv]
`timescale 1ns / 1ps

package meadj_pkg;

  localparam int TRI_W  = 11;
  localparam int VTX_W  = 12;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 10;

  localparam int MAX_EDGES_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [STAT_W-1:0] ST_NEW    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SECOND = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOOP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_SHARED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

  // ordered side as it travels from front to back
  typedef struct packed {
    logic [TRI_W-1:0] triangle;
    logic [VTX_W-1:0] lo;
    logic [VTX_W-1:0] hi;
    logic             is_loop;
  } item_t;

  // one row of the edge table
  typedef struct packed {
    logic [VTX_W-1:0] low_vertex;
    logic [VTX_W-1:0] high_vertex;
    logic [TRI_W-1:0] first_triangle;
    logic [TRI_W-1:0] second_triangle;
    logic             second_present;
  } entry_t;

endpackage

[hdl/meadj_ram.sv]
`timescale 1ns / 1ps

module meadj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/meadj_front.sv]
`timescale 1ns / 1ps

module meadj_front
  import meadj_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [TRI_W-1:0] triangle_id,
  input  logic [VTX_W-1:0] vertex_a,
  input  logic [VTX_W-1:0] vertex_b,
  output logic             item_valid,
  input  logic             item_ready,
  output item_t            item
);

  item_t sorted;

  always_comb begin
    sorted.triangle = triangle_id;
    sorted.lo       = (vertex_a < vertex_b) ? vertex_a : vertex_b;
    sorted.hi       = (vertex_a < vertex_b) ? vertex_b : vertex_a;
    sorted.is_loop  = (vertex_a == vertex_b);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= sorted;
    end
  end

endmodule

[hdl/meadj_queue.sv]
`timescale 1ns / 1ps

module meadj_queue
  import meadj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/meadj_back.sv]
`timescale 1ns / 1ps

module meadj_back
  import meadj_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] edge_slot,
  output logic [VTX_W-1:0]  low_vertex,
  output logic [VTX_W-1:0]  high_vertex
);

  localparam int IDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0]        state;
  item_t             cur;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  iss;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_idx;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic              hit;
  logic              miss;
  logic              full;
  logic [IDX_W-1:0]  slot_idx;
  logic [SLOT_W+IDX_W-1:0] slot_ext;
  logic              out_free;

  meadj_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_EDGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign hit  = chk_valid && (rd_entry.low_vertex == cur.lo) &&
                (rd_entry.high_vertex == cur.hi);
  assign miss = !chk_valid && (iss == cnt);
  assign full = (cnt == CNT_W'(MAX_EDGES));

  assign item_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign ram_re     = (state == S_SEARCH) && !hit && (iss != cnt);

  assign slot_idx = hit ? chk_idx : cnt[IDX_W-1:0];
  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[IDX_W-1:0];
    wr_entry  = rd_entry;
    if (state == S_SEARCH) begin
      if (hit) begin
        ram_we                   = !rd_entry.second_present;
        ram_waddr                = chk_idx;
        wr_entry.second_triangle = cur.triangle;
        wr_entry.second_present  = 1'b1;
      end else if (miss) begin
        ram_we                   = !full;
        wr_entry.low_vertex      = cur.lo;
        wr_entry.high_vertex     = cur.hi;
        wr_entry.first_triangle  = cur.triangle;
        wr_entry.second_triangle = '0;
        wr_entry.second_present  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a result taken while a new one is loaded keeps out_valid high
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.is_loop) begin
              res_status <= ST_LOOP;
              res_slot   <= '0;
              state      <= S_EMIT;
            end else begin
              iss       <= '0;
              chk_valid <= 1'b0;
              state     <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            res_status <= rd_entry.second_present ? ST_SHARED : ST_SECOND;
            res_slot   <= rd_entry.second_present ? '0 : slot_ext[SLOT_W-1:0];
            chk_valid  <= 1'b0;
            state      <= S_EMIT;
          end else if (miss) begin
            res_status <= full ? ST_FULL : ST_NEW;
            res_slot   <= full ? '0 : slot_ext[SLOT_W-1:0];
            if (!full) begin
              cnt <= cnt + 1'b1;
            end
            state <= S_EMIT;
          end else begin
            chk_valid <= ram_re;
            chk_idx   <= iss[IDX_W-1:0];
            if (ram_re) begin
              iss <= iss + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            edge_slot   <= res_slot;
            low_vertex  <= cur.lo;
            high_vertex <= cur.hi;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cur <= item;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(MAX_EDGES))
    else $error("edge count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> state == S_EMIT && (res_status == ST_NEW || res_status == ST_SECOND))
    else $error("table write without a matching result");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && miss && !full) |=> cnt == $past(cnt) + 1'b1)
    else $error("append did not advance edge count");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> iss <= cnt)
    else $error("search issued past last valid entry");

endmodule

[hdl/mesh_edge_adjacency_table_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    triangle_id, vertex_a, vertex_b
// out       output     out_valid / out_ready  status, edge_slot, low_vertex, high_vertex
//
// the back end takes a self loop from the queue and loads the result register directly;
// any other side is searched with one table read per stored entry on the single read
// port, each read compared against the side, until a hit or the last stored entry,
// then loads the result register; a side on an empty table goes straight to the result
// reset clears the edge count and all valid flags; table rows are written before read
// the front stage and a two-entry queue keep taking transactions while the
// search runs or while a finished result waits for out_ready

module mesh_edge_adjacency_table_top
  import meadj_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TRI_W-1:0]  triangle_id,
  input  logic [VTX_W-1:0]  vertex_a,
  input  logic [VTX_W-1:0]  vertex_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] edge_slot,
  output logic [VTX_W-1:0]  low_vertex,
  output logic [VTX_W-1:0]  high_vertex
);

  // front stage output: ordered pair plus self loop flag
  logic  fr_valid;
  logic  fr_ready;
  item_t fr_item;

  // queue head toward the search engine
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // orders the pair and flags self loops
  meadj_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .triangle_id (triangle_id),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .item_valid  (fr_valid),
    .item_ready  (fr_ready),
    .item        (fr_item)
  );

  // decouples classification from the search
  meadj_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // table search, insert or update, result register
  meadj_back #(
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item        (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .edge_slot   (edge_slot),
    .low_vertex  (low_vertex),
    .high_vertex (high_vertex)
  );

endmodule
